// ===== rtl/core/ucer_pkg.sv =====
package ucer_pkg;

	localparam int unsigned EP0_SIZE = 64;
	localparam int unsigned REG_COUNT = 7;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		KIND_SETUP = 2'd0,
		KIND_IN    = 2'd1,
		KIND_OUT   = 2'd2,
		KIND_RESET = 2'd3
	} evt_kind_t;

	typedef enum logic [1:0] {
		RESP_ACK   = 2'd0,
		RESP_NAK   = 2'd1,
		RESP_STALL = 2'd2
	} resp_t;

	localparam logic [1:0] TYPE_STANDARD = 2'd0;
	localparam logic [1:0] TYPE_CLASS    = 2'd1;

	localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
	localparam logic [7:0] REQ_NONE           = 8'hff;

	localparam logic [7:0] DT_DEVICE = 8'd1;
	localparam logic [7:0] DT_CONFIG = 8'd2;
	localparam logic [7:0] DT_STRING = 8'd3;
	localparam logic [7:0] STR_LAST  = 8'd4;

	localparam logic [3:0] SRC_NONE        = 4'd0;
	localparam logic [3:0] SRC_DEVICE      = 4'd1;
	localparam logic [3:0] SRC_CONFIG      = 4'd2;
	localparam logic [3:0] SRC_LANG        = 4'd3;
	localparam logic [3:0] SRC_SERIAL      = 4'd6;
	localparam logic [3:0] SRC_CONFIG_BYTE = 4'd8;
	localparam logic [3:0] SRC_STATUS      = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIG_LEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LANG_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERIAL_LEN = 3'd5;

	typedef logic [REG_COUNT-1:0][7:0] cfg_lens_t;

	localparam cfg_lens_t CFG_RESET = {8'd2, 8'd2, 8'd2, 8'd2, 8'd4, 8'd67, 8'd18};

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  endpoint;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] value_field;
		logic [15:0] length_field;
	} evt_item_t;

	typedef struct packed {
		logic [1:0] tx_response;
		logic       tx_toggle;
		logic       rx_response;
		logic       rx_toggle;
		logic [6:0] tx_length;
		logic [3:0] data_source;
		logic [7:0] data_offset;
		logic [6:0] device_address;
		logic [7:0] configuration;
		logic       enumerated;
		logic       class_request;
	} res_item_t;

	typedef struct packed {
		logic [7:0]  last_request;
		logic [1:0]  last_type;
		logic [15:0] bytes_left;
		logic [6:0]  pending_address;
		logic [6:0]  current_address;
		logic [7:0]  current_config;
		logic        enum_done;
		logic [3:0]  descr_source;
		logic [7:0]  descr_position;
		logic        in_toggle;
		resp_t       tx_resp;
		logic        rx_stall;
		logic        rx_toggle;
		logic [6:0]  tx_len;
		logic [7:0]  chunk_offset;
	} ucer_state_t;

	localparam ucer_state_t STATE_RESET = '{
		last_request:    8'd0,
		last_type:       2'd0,
		bytes_left:      16'd0,
		pending_address: 7'd0,
		current_address: 7'd0,
		current_config:  8'd0,
		enum_done:       1'b0,
		descr_source:    SRC_NONE,
		descr_position:  8'd0,
		in_toggle:       1'b0,
		tx_resp:         RESP_NAK,
		rx_stall:        1'b0,
		rx_toggle:       1'b0,
		tx_len:          7'd0,
		chunk_offset:    8'd0
	};

	function automatic logic [6:0] chunk_len(input logic [15:0] left);
		chunk_len = (left >= 16'(EP0_SIZE)) ? 7'(EP0_SIZE) : left[6:0];
	endfunction

endpackage

// ===== rtl/core/usb_control_endpoint_responder.sv =====
// channel | signals                          | item
// evt     | evt_valid, evt_ready, evt        | token event on the bus (evt_item_t)
// res     | res_valid, res_ready, res        | endpoint state after the event (res_item_t)
// cfg     | cfg_valid, cfg_ready, cfg_index, | write of one descriptor length register
//         | cfg_data                         |
// One item per cycle while res does not stall; a result is offered from the result register.
// An input register and a result register frame one pass of the request decoder.
// The result register refills while its item is taken, so a stalled res side holds
// one result plus one item in the input register, then drops evt_ready.
// Reset restores the lengths to their defaults and the endpoint to address 0, unconfigured.
module usb_control_endpoint_responder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	output logic                           evt_ready,
	input  ucer_pkg::evt_item_t            evt,
	output logic                           res_valid,
	input  logic                           res_ready,
	output ucer_pkg::res_item_t            res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ucer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	logic                item_valid_s1;
	ucer_pkg::evt_item_t item_s1;
	logic                res_valid_s2;
	ucer_pkg::res_item_t res_s2;
	ucer_pkg::res_item_t result;
	ucer_pkg::cfg_lens_t lens;
	logic                advance;

	assign advance   = item_valid_s1 && (!res_valid_s2 || res_ready);
	assign evt_ready = !item_valid_s1 || advance;
	assign cfg_ready = 1'b1;

	ucer_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.lens     (lens)
	);

	ucer_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.lens    (lens),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			item_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			item_s1 <= evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

// ===== rtl/core/ucer_cfg.sv =====
module ucer_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ucer_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                     wr_data,
	output ucer_pkg::cfg_lens_t            lens
);

	ucer_pkg::cfg_lens_t lens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_q <= ucer_pkg::CFG_RESET;
		end else if (wr_en && (32'(wr_index) < ucer_pkg::REG_COUNT)) begin
			lens_q[wr_index] <= wr_data;
		end
	end

	assign lens = lens_q;

endmodule

// ===== rtl/core/ucer_core.sv =====
module ucer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  ucer_pkg::evt_item_t   item,
	input  ucer_pkg::cfg_lens_t   lens,
	output ucer_pkg::res_item_t   result
);

	ucer_pkg::ucer_state_t state_q;
	ucer_pkg::ucer_state_t nxt;
	logic                                 cls;
	logic                                 ok;
	logic [7:0]                           vh;
	logic [7:0]                           vl;
	logic [1:0]                           rtype;
	logic [3:0]                           dsrc;
	logic [ucer_pkg::CFG_IDX_W-1:0]       dreg;
	logic [7:0]                           dlen;
	logic [15:0]                          clamp;
	logic [6:0]                           n_setup;
	logic [6:0]                           n_in;

	assign vh    = item.value_field[15:8];
	assign vl    = item.value_field[7:0];
	assign rtype = item.request_type[6:5];

	always_comb begin
		case (vh)
			ucer_pkg::DT_DEVICE: begin
				dsrc = ucer_pkg::SRC_DEVICE;
				dreg = ucer_pkg::REG_DEVICE_LEN;
			end
			ucer_pkg::DT_CONFIG: begin
				dsrc = ucer_pkg::SRC_CONFIG;
				dreg = ucer_pkg::REG_CONFIG_LEN;
			end
			default: begin
				if (vl <= ucer_pkg::STR_LAST) begin
					dsrc = ucer_pkg::SRC_LANG + {1'b0, vl[2:0]};
					dreg = ucer_pkg::REG_LANG_LEN + vl[2:0];
				end else begin
					dsrc = ucer_pkg::SRC_SERIAL;
					dreg = ucer_pkg::REG_SERIAL_LEN;
				end
			end
		endcase
	end

	assign dlen    = lens[dreg];
	assign clamp   = (item.length_field > {8'd0, dlen}) ? {8'd0, dlen} : item.length_field;
	assign n_setup = ucer_pkg::chunk_len(clamp);
	assign n_in    = ucer_pkg::chunk_len(state_q.bytes_left);

	always_comb begin
		nxt = state_q;
		cls = 1'b0;
		ok  = 1'b1;
		case (item.kind)
			ucer_pkg::KIND_SETUP: begin
				nxt.bytes_left     = item.length_field;
				nxt.last_request   = item.request_code;
				nxt.last_type      = rtype;
				nxt.descr_position = 8'd0;
				nxt.chunk_offset   = 8'd0;
				nxt.tx_len         = 7'd0;
				nxt.descr_source   = ucer_pkg::SRC_NONE;
				if (rtype == ucer_pkg::TYPE_CLASS) begin
					cls = 1'b1;
				end else if (rtype != ucer_pkg::TYPE_STANDARD) begin
					ok = 1'b0;
				end else begin
					case (item.request_code)
						ucer_pkg::REQ_GET_DESCRIPTOR: begin
							if (vh inside {ucer_pkg::DT_DEVICE, ucer_pkg::DT_CONFIG,
									ucer_pkg::DT_STRING}) begin
								nxt.descr_source   = dsrc;
								nxt.descr_position = {1'b0, n_setup};
								nxt.bytes_left     = clamp - {9'd0, n_setup};
								nxt.tx_len         = n_setup;
							end else begin
								ok = 1'b0;
							end
						end
						ucer_pkg::REQ_SET_ADDRESS: begin
							nxt.pending_address = vl[6:0];
							nxt.descr_source    = ucer_pkg::SRC_STATUS;
							nxt.bytes_left      = 16'd0;
						end
						ucer_pkg::REQ_GET_CONFIG: begin
							nxt.descr_source = ucer_pkg::SRC_CONFIG_BYTE;
							nxt.tx_len       = (item.length_field > 16'd1) ? 7'd1
								: item.length_field[6:0];
							nxt.bytes_left   = 16'd0;
						end
						ucer_pkg::REQ_SET_CONFIG: begin
							nxt.current_config = vl;
							nxt.enum_done      = 1'b1;
							nxt.descr_source   = ucer_pkg::SRC_STATUS;
							nxt.bytes_left     = 16'd0;
						end
						ucer_pkg::REQ_GET_STATUS: begin
							nxt.descr_source = ucer_pkg::SRC_STATUS;
							nxt.tx_len       = (item.length_field > 16'd2) ? 7'd2
								: item.length_field[6:0];
							nxt.bytes_left   = 16'd0;
						end
						default: begin
							ok = 1'b0;
						end
					endcase
				end
				if (ok) begin
					nxt.tx_resp  = ucer_pkg::RESP_ACK;
					nxt.rx_stall = 1'b0;
				end else begin
					nxt.last_request = ucer_pkg::REQ_NONE;
					nxt.tx_resp      = ucer_pkg::RESP_STALL;
					nxt.rx_stall     = 1'b1;
					nxt.tx_len       = 7'd0;
					nxt.descr_source = ucer_pkg::SRC_NONE;
					nxt.chunk_offset = 8'd0;
				end
				nxt.in_toggle = 1'b1;
				nxt.rx_toggle = 1'b1;
			end
			ucer_pkg::KIND_IN: begin
				if (item.endpoint == 4'd0) begin
					if (state_q.last_type == ucer_pkg::TYPE_CLASS) begin
						cls = 1'b1;
					end else if (state_q.last_request == ucer_pkg::REQ_GET_DESCRIPTOR) begin
						nxt.chunk_offset   = state_q.descr_position;
						nxt.descr_position = state_q.descr_position + {1'b0, n_in};
						nxt.bytes_left     = state_q.bytes_left - {9'd0, n_in};
						nxt.tx_len         = n_in;
						nxt.in_toggle      = ~state_q.in_toggle;
					end else begin
						if (state_q.last_request == ucer_pkg::REQ_SET_ADDRESS) begin
							nxt.current_address = state_q.pending_address;
						end
						nxt.tx_resp   = ucer_pkg::RESP_NAK;
						nxt.in_toggle = 1'b0;
						nxt.rx_stall  = 1'b0;
						nxt.rx_toggle = 1'b1;
					end
				end
			end
			ucer_pkg::KIND_OUT: begin
				if (item.endpoint == 4'd0) begin
					if (state_q.last_type == ucer_pkg::TYPE_CLASS) begin
						cls = 1'b1;
					end else begin
						nxt.tx_resp   = ucer_pkg::RESP_ACK;
						nxt.in_toggle = 1'b1;
						nxt.rx_stall  = 1'b0;
						nxt.rx_toggle = 1'b0;
					end
				end
			end
			default: begin
				nxt.tx_resp         = ucer_pkg::RESP_NAK;
				nxt.rx_stall        = 1'b0;
				nxt.in_toggle       = 1'b0;
				nxt.rx_toggle       = 1'b0;
				nxt.tx_len          = 7'd0;
				nxt.enum_done       = 1'b0;
				nxt.current_config  = 8'd0;
				nxt.pending_address = 7'd0;
				nxt.current_address = 7'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucer_pkg::STATE_RESET;
		end else if (step_en) begin
			state_q <= nxt;
		end
	end

	always_comb begin
		result.tx_response    = nxt.tx_resp;
		result.tx_toggle      = nxt.in_toggle;
		result.rx_response    = nxt.rx_stall;
		result.rx_toggle      = nxt.rx_toggle;
		result.tx_length      = nxt.tx_len;
		result.data_source    = nxt.descr_source;
		result.data_offset    = nxt.chunk_offset;
		result.device_address = nxt.current_address;
		result.configuration  = nxt.current_config;
		result.enumerated     = nxt.enum_done;
		result.class_request  = cls;
	end

`ifndef SYNTH
	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.tx_len <= 7'(ucer_pkg::EP0_SIZE))
		else $error("chunk longer than endpoint size");

	a_stall_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rx_stall == (state_q.tx_resp == ucer_pkg::RESP_STALL))
		else $error("IN and OUT stall disagree");

	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.tx_resp == ucer_pkg::RESP_STALL) |->
		(state_q.tx_len == 7'd0 && state_q.descr_source == ucer_pkg::SRC_NONE
		&& state_q.last_request == ucer_pkg::REQ_NONE))
		else $error("stalled request left data pending");

	a_setup_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.kind == ucer_pkg::KIND_SETUP) |=>
		(state_q.in_toggle && state_q.rx_toggle))
		else $error("setup did not set both toggles");
`endif

endmodule

// ===== verif/tb_usb_control_endpoint_responder.sv =====
`timescale 1ns / 100ps

module tb_usb_control_endpoint_responder;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 200;
	localparam int PHASE_COUNT    = 6;

	localparam logic [1:0] TYPE_VENDOR   = 2'd2;
	localparam logic [1:0] TYPE_RESERVED = 2'd3;
	localparam logic [7:0] REQ_BOGUS     = 8'hfe;
	localparam logic [7:0] CLASS_CODE    = 8'h22;
	localparam logic [7:0] DT_BOGUS      = 8'hff;
	localparam logic [ucer_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum {LENS_ZERO, LENS_FULL, LENS_RANDOM} lens_mode_t;

	class ep0_tracker;
		logic [7:0]          len_reg [ucer_pkg::REG_COUNT];
		logic [7:0]          req_code;
		logic [7:0]          req_type;
		logic [15:0]         remaining;
		logic [7:0]          addr_pending;
		logic [6:0]          addr_now;
		logic [7:0]          cfg_now;
		logic                configured;
		logic [3:0]          source;
		logic [7:0]          next_offset;
		logic                tog_in;
		ucer_pkg::resp_t     hs_in;
		logic                stall_out;
		logic                tog_out;
		logic [6:0]          pkt_len;
		logic [7:0]          pkt_offset;
		ucer_pkg::res_item_t pending_results[$];
		int                  failures;
		int                  results_seen;

		function new();
			failures = 0;
			results_seen = 0;
			for (int i = 0; i < ucer_pkg::REG_COUNT; i++)
				len_reg[i] = ucer_pkg::CFG_RESET[i];
			req_code = 8'd0;
			req_type = 8'd0;
			remaining = 16'd0;
			source = ucer_pkg::SRC_NONE;
			next_offset = 8'd0;
			pkt_offset = 8'd0;
			bus_reset();
		endfunction

		function void bus_reset();
			hs_in = ucer_pkg::RESP_NAK;
			stall_out = 1'b0;
			tog_in = 1'b0;
			tog_out = 1'b0;
			pkt_len = 7'd0;
			configured = 1'b0;
			cfg_now = 8'd0;
			addr_pending = 8'd0;
			addr_now = 7'd0;
		endfunction

		function void write_len(logic [ucer_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
			if (idx < ucer_pkg::REG_COUNT)
				len_reg[idx] = data;
		endfunction

		function bit is_class();
			return req_type[6:5] == ucer_pkg::TYPE_CLASS;
		endfunction

		function void take_chunk();
			logic [15:0] n;
			n = (remaining >= ucer_pkg::EP0_SIZE) ? 16'(ucer_pkg::EP0_SIZE) : remaining;
			pkt_offset = next_offset;
			next_offset = next_offset + n[7:0];
			remaining = remaining - n;
			pkt_len = n[6:0];
		endfunction

		function bit decode_setup(ucer_pkg::evt_item_t e);
			logic [7:0] dtype;
			logic [7:0] dindex;
			logic [7:0] dlen;
			dtype = e.value_field[15:8];
			dindex = e.value_field[7:0];
			next_offset = 8'd0;
			pkt_offset = 8'd0;
			pkt_len = 7'd0;
			source = ucer_pkg::SRC_NONE;
			if (req_type[6:5] == ucer_pkg::TYPE_CLASS)
				return 1'b1;
			if (req_type[6:5] != ucer_pkg::TYPE_STANDARD)
				return 1'b0;
			case (req_code)
				ucer_pkg::REQ_GET_DESCRIPTOR: begin
					if (dtype == ucer_pkg::DT_DEVICE)
						source = ucer_pkg::SRC_DEVICE;
					else if (dtype == ucer_pkg::DT_CONFIG)
						source = ucer_pkg::SRC_CONFIG;
					else if (dtype == ucer_pkg::DT_STRING)
						source = (dindex <= ucer_pkg::STR_LAST)
							? ucer_pkg::SRC_LANG + dindex[3:0] : ucer_pkg::SRC_SERIAL;
					else
						return 1'b0;
					if (source == ucer_pkg::SRC_DEVICE)
						dlen = len_reg[ucer_pkg::REG_DEVICE_LEN];
					else if (source == ucer_pkg::SRC_CONFIG)
						dlen = len_reg[ucer_pkg::REG_CONFIG_LEN];
					else
						dlen = len_reg[int'(ucer_pkg::REG_LANG_LEN) + int'(source)
							- int'(ucer_pkg::SRC_LANG)];
					if (remaining > dlen)
						remaining = {8'd0, dlen};
					take_chunk();
					return 1'b1;
				end
				ucer_pkg::REQ_SET_ADDRESS: begin
					addr_pending = dindex;
					source = ucer_pkg::SRC_STATUS;
					remaining = 16'd0;
					return 1'b1;
				end
				ucer_pkg::REQ_GET_CONFIG: begin
					source = ucer_pkg::SRC_CONFIG_BYTE;
					pkt_len = (remaining > 16'd1) ? 7'd1 : remaining[6:0];
					remaining = 16'd0;
					return 1'b1;
				end
				ucer_pkg::REQ_SET_CONFIG: begin
					cfg_now = dindex;
					configured = 1'b1;
					source = ucer_pkg::SRC_STATUS;
					remaining = 16'd0;
					return 1'b1;
				end
				ucer_pkg::REQ_GET_STATUS: begin
					source = ucer_pkg::SRC_STATUS;
					pkt_len = (remaining > 16'd2) ? 7'd2 : remaining[6:0];
					remaining = 16'd0;
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void note_event(ucer_pkg::evt_item_t e);
			ucer_pkg::res_item_t r;
			logic cls;
			cls = 1'b0;
			case (e.kind)
				ucer_pkg::KIND_SETUP: begin
					remaining = e.length_field;
					req_code = e.request_code;
					req_type = e.request_type;
					cls = is_class();
					if (decode_setup(e)) begin
						hs_in = ucer_pkg::RESP_ACK;
						stall_out = 1'b0;
					end else begin
						req_code = ucer_pkg::REQ_NONE;
						hs_in = ucer_pkg::RESP_STALL;
						stall_out = 1'b1;
						pkt_len = 7'd0;
						source = ucer_pkg::SRC_NONE;
						pkt_offset = 8'd0;
					end
					tog_in = 1'b1;
					tog_out = 1'b1;
				end
				ucer_pkg::KIND_IN: begin
					if (e.endpoint == 4'd0) begin
						if (is_class()) begin
							cls = 1'b1;
						end else if (req_code == ucer_pkg::REQ_GET_DESCRIPTOR) begin
							take_chunk();
							tog_in = ~tog_in;
						end else begin
							if (req_code == ucer_pkg::REQ_SET_ADDRESS)
								addr_now = addr_pending[6:0];
							hs_in = ucer_pkg::RESP_NAK;
							tog_in = 1'b0;
							stall_out = 1'b0;
							tog_out = 1'b1;
						end
					end
				end
				ucer_pkg::KIND_OUT: begin
					if (e.endpoint == 4'd0) begin
						if (is_class()) begin
							cls = 1'b1;
						end else begin
							hs_in = ucer_pkg::RESP_ACK;
							tog_in = 1'b1;
							stall_out = 1'b0;
							tog_out = 1'b0;
						end
					end
				end
				default: bus_reset();
			endcase
			r.tx_response = hs_in;
			r.tx_toggle = tog_in;
			r.rx_response = stall_out;
			r.rx_toggle = tog_out;
			r.tx_length = pkt_len;
			r.data_source = source;
			r.data_offset = pkt_offset;
			r.device_address = addr_now;
			r.configuration = cfg_now;
			r.enumerated = configured;
			r.class_request = cls;
			pending_results.push_back(r);
		endfunction

		function void compare(string fname, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", fname, want, got);
				failures++;
			end
		endfunction

		function void match_result(ucer_pkg::res_item_t got);
			ucer_pkg::res_item_t want;
			if (pending_results.size() == 0) begin
				$error("result arrived with nothing expected");
				failures++;
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			compare("tx_response", want.tx_response, got.tx_response);
			compare("tx_toggle", want.tx_toggle, got.tx_toggle);
			compare("rx_response", want.rx_response, got.rx_response);
			compare("rx_toggle", want.rx_toggle, got.rx_toggle);
			compare("tx_length", want.tx_length, got.tx_length);
			compare("data_source", want.data_source, got.data_source);
			compare("data_offset", want.data_offset, got.data_offset);
			compare("device_address", want.device_address, got.device_address);
			compare("configuration", want.configuration, got.configuration);
			compare("enumerated", want.enumerated, got.enumerated);
			compare("class_request", want.class_request, got.class_request);
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           evt_valid = 1'b0;
	logic                           evt_ready;
	ucer_pkg::evt_item_t            evt = '0;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	ucer_pkg::res_item_t            res;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ucer_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                     cfg_data = '0;

	ep0_tracker tracker = new();
	bit quiet = 1'b0;
	bit calm = 1'b0;
	int sent_items = 0;
	int writes = 0;
	int idle_cycles = 0;
	int stall_left = 0;

	usb_control_endpoint_responder uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid && evt_ready)
				tracker.note_event(evt);
			if (res_valid && res_ready)
				tracker.match_result(res);
			if (cfg_valid && cfg_ready) begin
				tracker.write_len(cfg_index, cfg_data);
				writes++;
			end
			if ((evt_valid && evt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 6);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	function automatic logic [7:0] req_type_byte(logic dir, logic [1:0] tp);
		return {dir, tp, 5'd0};
	endfunction

	task automatic hold_off(int n);
		@(negedge clk);
		evt_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send(ucer_pkg::evt_item_t item);
		if (!quiet && !calm && $urandom_range(0, 4) == 0)
			hold_off($urandom_range(1, 7));
		@(negedge clk);
		evt <= item;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!evt_ready);
		sent_items++;
	endtask

	task automatic post(ucer_pkg::evt_kind_t kind, logic [3:0] ep, logic [7:0] rtype,
			logic [7:0] code, logic [15:0] value, logic [15:0] len);
		ucer_pkg::evt_item_t item;
		item.kind = kind;
		item.endpoint = ep;
		item.request_type = rtype;
		item.request_code = code;
		item.value_field = value;
		item.length_field = len;
		send(item);
	endtask

	task automatic token(ucer_pkg::evt_kind_t kind, logic [3:0] ep);
		post(kind, ep, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
	endtask

	task automatic settle();
		hold_off(1);
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [ucer_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_lengths(lens_mode_t mode);
		logic [7:0] data;
		for (int i = 0; i < ucer_pkg::REG_COUNT; i++) begin
			case (mode)
				LENS_ZERO: data = 8'd0;
				LENS_FULL: data = 8'hff;
				default: data = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 80))
					: 8'($urandom_range(0, 255));
			endcase
			write_reg(ucer_pkg::CFG_IDX_W'(i), data);
		end
	endtask

	task automatic standard_transfer();
		logic [7:0]  rtype;
		logic [7:0]  code;
		logic [7:0]  dtype;
		logic [7:0]  dindex;
		logic [15:0] len;
		logic [3:0]  ep;
		int          n_in;
		rtype = 8'($urandom_range(0, 255));
		rtype[6:5] = ucer_pkg::TYPE_STANDARD;
		case ($urandom_range(0, 7))
			0: code = ucer_pkg::REQ_GET_STATUS;
			1: code = ucer_pkg::REQ_SET_ADDRESS;
			2: code = ucer_pkg::REQ_GET_CONFIG;
			3: code = ucer_pkg::REQ_SET_CONFIG;
			7: code = 8'($urandom_range(0, 255));
			default: code = ucer_pkg::REQ_GET_DESCRIPTOR;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2: dtype = ucer_pkg::DT_DEVICE;
			3, 4, 5: dtype = ucer_pkg::DT_CONFIG;
			6, 7, 8: dtype = ucer_pkg::DT_STRING;
			default: dtype = 8'($urandom_range(0, 255));
		endcase
		dindex = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 5));
		case ($urandom_range(0, 9))
			0: len = 16'($urandom_range(0, 65535));
			1: len = 16'd0;
			default: len = 16'($urandom_range(0, 300));
		endcase
		ep = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
		post(ucer_pkg::KIND_SETUP, ep, rtype, code, {dtype, dindex}, len);
		n_in = (code == ucer_pkg::REQ_GET_DESCRIPTOR) ? $urandom_range(1, 6)
			: $urandom_range(0, 2);
		repeat (n_in)
			token(ucer_pkg::KIND_IN,
				($urandom_range(0, 19) == 0) ? 4'($urandom_range(1, 15)) : 4'd0);
		if ($urandom_range(0, 3) != 0)
			token(ucer_pkg::KIND_OUT, 4'd0);
	endtask

	task automatic class_transfer();
		logic [7:0] rtype;
		rtype = 8'($urandom_range(0, 255));
		rtype[6:5] = ucer_pkg::TYPE_CLASS;
		post(ucer_pkg::KIND_SETUP, 4'd0, rtype, 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		repeat ($urandom_range(0, 3))
			token(($urandom_range(0, 1) == 0) ? ucer_pkg::KIND_IN : ucer_pkg::KIND_OUT, 4'd0);
	endtask

	task automatic broken_transfer();
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_CONFIG, 8'd0},
			16'($urandom_range(65, 65535)));
		token(ucer_pkg::KIND_IN, 4'd0);
		token(ucer_pkg::KIND_RESET, 4'($urandom_range(0, 15)));
		token(ucer_pkg::KIND_IN, 4'd0);
	endtask

	task automatic run_transfers(int count);
		int start;
		int pick;
		start = sent_items;
		while (sent_items - start < count) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				standard_transfer();
			else if (pick < 80)
				class_transfer();
			else if (pick < 86)
				broken_transfer();
			else
				token(ucer_pkg::evt_kind_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 49) == 0)
				settle();
		end
		calm = 1'b0;
	endtask

	task automatic directed();
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_DEVICE, 8'd0}, 16'hffff);
		token(ucer_pkg::KIND_IN, 4'd0);
		token(ucer_pkg::KIND_OUT, 4'd0);
		post(ucer_pkg::KIND_SETUP, 4'hf, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_CONFIG, 8'd0}, 16'hffff);
		token(ucer_pkg::KIND_IN, 4'd0);
		token(ucer_pkg::KIND_IN, 4'd0);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_STRING, 8'd0}, 16'h00ff);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_STRING, ucer_pkg::STR_LAST}, 16'hffff);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_STRING, 8'hff}, 16'd1);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_DESCRIPTOR, {DT_BOGUS, 8'hff}, 16'hffff);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b0, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_SET_ADDRESS, 16'h00ff, 16'd0);
		token(ucer_pkg::KIND_IN, 4'd5);
		token(ucer_pkg::KIND_IN, 4'd0);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b0, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_SET_CONFIG, 16'hffff, 16'd0);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_CONFIG, 16'd0, 16'hffff);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			ucer_pkg::REQ_GET_STATUS, 16'd0, 16'd1);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b0, ucer_pkg::TYPE_CLASS),
			CLASS_CODE, 16'd0, 16'd7);
		token(ucer_pkg::KIND_IN, 4'd0);
		token(ucer_pkg::KIND_OUT, 4'd0);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, TYPE_VENDOR),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_DEVICE, 8'd0}, 16'd18);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, TYPE_RESERVED),
			ucer_pkg::REQ_GET_DESCRIPTOR, {ucer_pkg::DT_DEVICE, 8'd0}, 16'd18);
		post(ucer_pkg::KIND_SETUP, 4'd0, req_type_byte(1'b1, ucer_pkg::TYPE_STANDARD),
			REQ_BOGUS, 16'd0, 16'd0);
		token(ucer_pkg::KIND_RESET, 4'd0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed();
		settle();
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: ;
				1: load_lengths(LENS_ZERO);
				2: load_lengths(LENS_FULL);
				default: load_lengths(LENS_RANDOM);
			endcase
			if (phase == PHASE_COUNT - 1) begin
				write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
				quiet = 1'b1;
			end
			run_transfers(PHASE_ITEMS);
			settle();
		end
		$display("covered %0d events and %0d results across %0d length settings",
			sent_items, tracker.results_seen, PHASE_COUNT);
		$display("applied %0d register writes, zero and full lengths included", writes);
		if (tracker.failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== usb_control_endpoint_responder.f =====
rtl/core/ucer_pkg.sv
rtl/core/ucer_cfg.sv
rtl/core/ucer_core.sv
rtl/core/usb_control_endpoint_responder.sv
verif/tb_usb_control_endpoint_responder.sv
